// ===== design/assert_macros.svh =====
// Assertion macros used by the checker of this project.
// No dependencies; each file that asserts includes this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/lkvc_pkg.sv =====
// Package for the LRU key/value cache: port widths and reset constants.
// No dependencies; used by the top level and its checker.
package lkvc_pkg;

    localparam int CAP_W      = 5;
    localparam int KEY_W      = 32;
    localparam int VALUE_W    = 32;
    localparam int OCC_W      = 5;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 40;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

// ===== design/lru_key_value_cache.sv =====
// Fully associative key/value cache with least-recently-used replacement.
// Depends on lkvc_pkg for port widths and the capacity reset value.

// The cache holds up to ENTRIES key/value pairs, all compared in parallel.
// A request item carries mode on s_tuser (0 lookup, 1 insert-or-assign) and
// key/value on s_tdata; each request yields exactly one result item with
// found on m_tuser and data/occupancy on m_tdata. A lookup hit returns the
// stored value and makes the entry most recent; a miss returns 0 and changes
// nothing. An insert-or-assign rewrites a present key, or stores a new key in
// the lowest free slot after evicting the least recent entry when occupancy
// has reached capacity. Capacity 0 acts as 1, capacity above ENTRIES as
// ENTRIES; lowering it below the occupancy evicts one entry per new insert.
// Timing: one item per cycle sustained while results are taken.
// The request lands in an input register; the whole compare, rank update
// and slot pick is one combinational pass into the result register, which
// also updates the entry state, so the next request sees it right away.
// The result register decouples the two sides: input stalls only while a
// result is held and the previous request waits behind it. The capacity
// write port is always ready and must be used only while the cache is idle.
module lru_key_value_cache #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // capacity write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lkvc_pkg::CAP_W-1:0]     cfg_data,   // capacity
    // request items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lkvc_pkg::S_TDATA_W-1:0] s_tdata,    // [31:0] key, [63:32] value
    input  logic                           s_tuser,    // [0] mode
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lkvc_pkg::M_TDATA_W-1:0] m_tdata,    // [31:0] data, [36:32] occupancy
    output logic                           m_tuser     // [0] found
);
    import lkvc_pkg::*;

    localparam int RW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW     = $clog2(ENTRIES + 1);
    localparam int KW     = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int VW     = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int CMP_W  = (OW > CAP_W) ? OW : CAP_W;

    // input register
    logic               in_valid_reg;
    logic               in_mode_reg;
    logic [KEY_W-1:0]   in_key_reg;
    logic [VALUE_W-1:0] in_value_reg;

    // result register
    logic               out_valid_reg;
    logic               out_found_reg;
    logic [VALUE_W-1:0] out_data_reg;
    logic [OCC_W-1:0]   out_occ_reg;

    logic [CAP_W-1:0]   capacity_reg;

    // entry state
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [KW-1:0]      key_reg   [ENTRIES];
    logic [VW-1:0]      value_reg [ENTRIES];
    logic [RW-1:0]      rank_reg  [ENTRIES];
    logic [RW-1:0]      rank_next [ENTRIES];
    logic [OW-1:0]      occ_reg;
    logic [OW-1:0]      occ_next;

    logic               advance;
    logic [KW-1:0]      key_m;
    logic [VW-1:0]      val_m;
    logic [ENTRIES-1:0] match;
    logic               hit;
    logic [RW-1:0]      hit_rank;
    logic [VW-1:0]      hit_value;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   cap_eff;
    logic               do_insert;
    logic               evict;
    logic [RW-1:0]      lru_rank;
    logic [ENTRIES-1:0] evict_mask;
    logic [ENTRIES-1:0] valid_left;
    logic [ENTRIES-1:0] free_mask;
    logic [ENTRIES-1:0] ins_mask;
    logic [VW-1:0]      data_now;

    // A request moves on when the result register is empty or being drained.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign key_m = in_key_reg[KW-1:0];
    assign val_m = in_value_reg[VW-1:0];

    // Keys of valid entries are unique, so at most one match bit is set and
    // the rank/value can be gathered by OR.
    always_comb
    begin
        hit_rank  = '0;
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == key_m);
            if (match[i])
            begin
                hit_rank  = hit_rank | rank_reg[i];
                hit_value = hit_value | value_reg[i];
            end
        end
    end

    assign hit = |match;

    // effective capacity: 0 acts as 1, clamp at ENTRIES
    always_comb
    begin
        cap_ext = CMP_W'(capacity_reg);
        if (cap_ext == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end

    assign do_insert = in_mode_reg && !hit;
    assign evict     = do_insert && (occ_reg != '0) && (CMP_W'(occ_reg) >= cap_eff);
    assign lru_rank  = RW'(occ_reg - OW'(1));

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            evict_mask[i] = evict && valid_reg[i] && (rank_reg[i] == lru_rank);
        end
    end

    // lowest free slot after the eviction, as a one-hot mask
    assign valid_left = valid_reg & ~evict_mask;
    assign free_mask  = ~valid_left;
    assign ins_mask   = free_mask & (~free_mask + ENTRIES'(1));

    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (hit)
            begin
                if (match[i])
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                begin
                    rank_next[i] = rank_reg[i] + RW'(1);
                end
            end
            else if (do_insert)
            begin
                if (ins_mask[i])
                begin
                    rank_next[i] = '0;
                end
                else if (valid_left[i])
                begin
                    rank_next[i] = rank_reg[i] + RW'(1);
                end
            end
        end
        if (do_insert)
        begin
            valid_next = valid_left | ins_mask;
        end
    end

    // an insert without eviction always finds a free slot
    assign occ_next = (do_insert && !evict) ? occ_reg + OW'(1) : occ_reg;
    assign data_now = in_mode_reg ? val_m : hit_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            capacity_reg  <= CAP_RESET;
            valid_reg     <= '0;
            occ_reg       <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                valid_reg     <= valid_next;
                occ_reg       <= occ_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    // payload registers and entry stores, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_mode_reg  <= s_tuser;
            in_key_reg   <= s_tdata[KEY_W-1:0];
            in_value_reg <= s_tdata[KEY_W +: VALUE_W];
        end
        if (advance)
        begin
            out_found_reg <= hit;
            out_data_reg  <= VALUE_W'(data_now);
            out_occ_reg   <= OCC_W'(occ_next);
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
                if (do_insert && ins_mask[i])
                begin
                    key_reg[i]   <= key_m;
                    value_reg[i] <= val_m;
                end
                else if (in_mode_reg && match[i])
                begin
                    value_reg[i] <= val_m;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = M_TDATA_W'({out_occ_reg, out_data_reg});

endmodule

// ===== design/lkvc_checker.sv =====
// Port-level checker for the LRU key/value cache, bound to the top level.
// Depends on lkvc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lkvc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lkvc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser
);
    import lkvc_pkg::*;

    logic [OCC_W-1:0] occ;
    logic             data_nz;

    assign occ     = m_tdata[VALUE_W +: OCC_W];
    assign data_nz = (m_tdata[VALUE_W-1:0] != '0);

    // a held result keeps its payload
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tuser, m_tdata}))

    // input backs up only behind a stalled result
    `ASSERT_SAME(a_stall_cause, !s_tready, m_tvalid && !m_tready)

    // a hit or a stored value means at least one entry is held
    `ASSERT_SAME(a_occ_nonzero, m_tvalid && (m_tuser || data_nz), occ != '0)

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for lru_key_value_cache: mirrors the LRU cache in
// a small class and checks every result item. Needs lkvc_pkg and the RTL.
// Stimulus covers capacity settings, hits, misses, assigns and evictions.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lkvc_pkg::*;

    localparam int ENTRIES  = 16;
    localparam int KEY_POOL = 24;
    localparam int PHASES   = 8;
    localparam int PHASE_ITEMS = 200;

    typedef enum bit {OP_LOOKUP = 1'b0, OP_INSERT = 1'b1} cache_op_t;

    typedef struct packed {
        bit                 found;
        logic [VALUE_W-1:0] data;
        logic [OCC_W-1:0]   occupancy;
    } cache_result_t;

    // Mirror of the cache contents; predicts one result per request item.
    class lru_cache_mirror_t;
        logic [KEY_W-1:0]   keys [ENTRIES];
        logic [VALUE_W-1:0] values [ENTRIES];
        bit                 valid [ENTRIES];
        int                 rank [ENTRIES];   // 0 = most recent
        logic [CAP_W-1:0]   capacity;
        cache_result_t      pending_results [$];
        int                 mismatches;

        function new();
            capacity   = CAP_RESET;
            mismatches = 0;
            foreach (valid[i]) valid[i] = 1'b0;
        endfunction

        function int occupied();
            int n;
            n = 0;
            foreach (valid[i]) n += int'(valid[i]);
            return n;
        endfunction

        function void accept_request(cache_op_t op, logic [KEY_W-1:0] key,
                                     logic [VALUE_W-1:0] value);
            cache_result_t r;
            int limit;
            int slot;
            int occ;
            int old_rank;
            limit = (capacity == 0) ? 1 : (capacity > ENTRIES) ? ENTRIES : int'(capacity);
            slot  = -1;
            r     = '0;
            foreach (valid[i])
                if (valid[i] && keys[i] == key) slot = i;
            if (slot >= 0) begin
                // hit: entries newer than this one age by one
                old_rank = rank[slot];
                foreach (valid[i])
                    if (valid[i] && rank[i] < old_rank) rank[i]++;
                rank[slot] = 0;
                if (op == OP_INSERT) values[slot] = value;
                r.found = 1'b1;
                r.data  = values[slot];
            end else if (op == OP_INSERT) begin
                // full (or over a lowered capacity): drop only the oldest entry
                occ = occupied();
                if (occ > 0 && occ >= limit)
                    foreach (valid[i])
                        if (valid[i] && rank[i] == occ - 1) valid[i] = 1'b0;
                for (int i = ENTRIES - 1; i >= 0; i--)
                    if (!valid[i]) slot = i;
                if (slot >= 0) begin
                    foreach (valid[i])
                        if (valid[i]) rank[i]++;
                    valid[slot]  = 1'b1;
                    keys[slot]   = key;
                    values[slot] = value;
                    rank[slot]   = 0;
                    r.data       = value;
                end
            end
            r.occupancy = OCC_W'(occupied());
            pending_results.push_back(r);
        endfunction

        function void check_result(bit found, logic [VALUE_W-1:0] data,
                                   logic [OCC_W-1:0] occupancy);
            cache_result_t exp_r;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: found=%0d data=%h occ=%0d",
                             found, data, occupancy);
                return;
            end
            exp_r = pending_results.pop_front();
            if (found !== exp_r.found || data !== exp_r.data
                    || occupancy !== exp_r.occupancy) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at %0t: expected found=%0d data=%h occ=%0d",
                             $realtime, exp_r.found, exp_r.data, exp_r.occupancy);
                    $display("    got found=%0d data=%h occ=%0d",
                             found, data, occupancy);
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CAP_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;    // [31:0] key, [63:32] value
    logic                 s_tuser;    // [0] mode
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;    // [31:0] data, [36:32] occupancy
    logic                 m_tuser;    // [0] found

    lru_cache_mirror_t mirror;
    int               idle_pct;       // sender gap chance, percent
    int               stall_pct;      // receiver stall chance, percent
    logic [KEY_W-1:0] key_pool [KEY_POOL];

    lru_key_value_cache uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop, far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Receiver: ready changes on falling edges, results taken on rising edges.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            mirror.check_result(m_tuser, m_tdata[VALUE_W-1:0],
                                m_tdata[VALUE_W +: OCC_W]);
    end

    // Called just after a falling edge; returns just after the falling edge
    // that follows acceptance, with tvalid still high.
    task automatic send_request(cache_op_t op, logic [KEY_W-1:0] key,
                                logic [VALUE_W-1:0] value);
        bit taken;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {value, key};
        do
        begin
            @(posedge clk);
            taken = s_tready;
            if (taken) mirror.accept_request(op, key, value);
            @(negedge clk);
        end
        while (!taken);
    endtask

    // Sender holds off until every expected result has come, plus a margin
    // for the two-stage pipeline.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (mirror.pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Only while the cache is idle.
    task automatic write_capacity(logic [CAP_W-1:0] cap);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do
        begin
            @(posedge clk);
            taken = cfg_ready;
            if (taken) mirror.capacity = cap;
        end
        while (!taken);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [CAP_W-1:0]   cap_plan [PHASES];
        cache_op_t          op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        int                 pick;

        mirror    = new();
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        idle_pct  = 0;
        stall_pct = 0;

        // 16 first, then 1 lowers capacity under a full cache; 0 acts as 1,
        // 31 saturates at ENTRIES.
        cap_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd2, 5'd12, 5'd16};

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty miss, field extremes, hit, assign, fill, eviction.
        send_request(OP_LOOKUP, 32'h0, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'h0, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0);
        send_request(OP_LOOKUP, 32'h0, 32'h0);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
        send_request(OP_LOOKUP, 32'h1, 32'h0);
        for (int i = 2; i < ENTRIES; i++)
            send_request(OP_INSERT, i, ~i);
        // full at reset capacity: key 0 is now the oldest and goes
        send_request(OP_INSERT, 32'h100, 32'h5A5A_5A5A);
        send_request(OP_LOOKUP, 32'h0, 32'h0);
        send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_for_results();
            write_capacity(cap_plan[p]);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 88; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // one mid-phase hold-off until the cache has drained
                if (p == 2 && n == PHASE_ITEMS / 2) wait_for_results();
                op   = ($urandom_range(0, 1) == 1) ? OP_INSERT : OP_LOOKUP;
                pick = $urandom_range(0, 99);
                key  = (pick < 12) ? $urandom : key_pool[$urandom_range(0, KEY_POOL - 1)];
                pick = $urandom_range(0, 99);
                value = (pick < 5) ? '0 : (pick < 10) ? '1 : $urandom;
                send_request(op, key, value);
            end
        end

        wait_for_results();
        repeat (8) @(posedge clk);
        if (mirror.pending_results.size() != 0)
            $display("%0d expected results never arrived",
                     mirror.pending_results.size());
        if (mirror.mismatches == 0 && mirror.pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
